// ===== hdl/nsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared constants and controller/datapath interface types for the
// Newton square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int DATA_W          = 32;
	localparam int TOL_W           = 16;
	localparam int STEPS_W         = 6;
	localparam int STEPS_SAT       = 63;
	localparam int MAX_ITERS_DEF   = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // take the radicand, first guess is half of it
		logic sq_mul;     // square the guess
		logic sq_err;     // absolute error of the square against the radicand
		logic div_start;  // load the divider with radicand and guess
		logic div_step;   // one radix-2 quotient bit
		logic update;     // average guess and quotient, count the step
		logic emit;       // move the result into the output register
	} nsr_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic err_gt;     // error above tolerance
		logic steps_cap;  // step cap reached
		logic div_last;   // last divider step in progress
		logic out_busy;   // output register full and not taken this cycle
	} nsr_sts_t;

endpackage
`default_nettype wire

// ===== hdl/nsr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_ctrl
// Sequencer for the Newton iteration: square, error check, divide, update.
// ----------------------------------------------------------------------------
module nsr_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  nsr_pkg::nsr_sts_t sts,
	output nsr_pkg::nsr_cmd_t cmd
);
	import nsr_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SQ_MUL    = 3'd1;
	localparam logic [2:0] ST_SQ_ERR    = 3'd2;
	localparam logic [2:0] ST_CHECK     = 3'd3;
	localparam logic [2:0] ST_DIV_START = 3'd4;
	localparam logic [2:0] ST_DIV_RUN   = 3'd5;
	localparam logic [2:0] ST_UPDATE    = 3'd6;
	localparam logic [2:0] ST_FINISH    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SQ_MUL;
				end
			end
			ST_SQ_MUL: begin
				cmd.sq_mul = 1'b1;
				state_nxt  = ST_SQ_ERR;
			end
			ST_SQ_ERR: begin
				cmd.sq_err = 1'b1;
				state_nxt  = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.err_gt && !sts.steps_cap)
					state_nxt = ST_DIV_START;
				else
					state_nxt = ST_FINISH;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = ST_SQ_MUL;
			end
			ST_FINISH: begin
				// wait here only while the previous result is still unclaimed
				if (!sts.out_busy) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule
`default_nettype wire

// ===== hdl/nsr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_dp
// Datapath: guess register, squarer, error unit, radix-2 restoring divider,
// step counter, tolerance register and output register.
// ----------------------------------------------------------------------------
module nsr_dp #(
	parameter int MAX_ITERS = nsr_pkg::MAX_ITERS_DEF,
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  nsr_pkg::nsr_cmd_t              cmd,
	output nsr_pkg::nsr_sts_t              sts,
	input  wire  [nsr_pkg::DATA_W-1:0]     radicand,
	input  wire                            cfg_we,
	input  wire  [nsr_pkg::TOL_W-1:0]      cfg_wdata,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [nsr_pkg::DATA_W-1:0]     out_root,
	output logic [nsr_pkg::STEPS_W-1:0]    out_steps,
	output logic                           out_not_conv
);
	import nsr_pkg::*;

	localparam int DIV_W   = DATA_W + FRAC_BITS;
	localparam int DCNT_W  = $clog2(DIV_W + 1);
	localparam int SCNT_RAW = $clog2(MAX_ITERS + 1);
	localparam int STEP_W  = (SCNT_RAW > STEPS_W) ? SCNT_RAW : STEPS_W;
	localparam int PROD_W  = 2 * DATA_W;

	logic [TOL_W-1:0]  tol_q;
	logic [DATA_W-1:0] rad_q;
	logic [DATA_W-1:0] guess_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] err_q;
	logic [STEP_W-1:0] step_q;

	logic [DATA_W:0]   rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [PROD_W-1:0] sq_w;
	logic [PROD_W-1:0] rad_w;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W+1:0] trial;
	logic [DIV_W:0]    sum_w;
	logic [DIV_W-1:0]  avg_w;
	logic [DATA_W-1:0] new_guess;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= TOL_RESET;
		else if (cfg_we)
			tol_q <= cfg_wdata;
	end

	assign sq_w  = prod_q >> FRAC_BITS;
	assign rad_w = PROD_W'(rad_q);

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q[DATA_W-1:0], quo_q[DIV_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};

	assign sum_w     = (DIV_W+1)'(quo_q) + (DIV_W+1)'(dvs_q);
	assign avg_w     = sum_w[DIV_W:1];
	assign new_guess = (avg_w > DIV_W'({DATA_W{1'b1}})) ? {DATA_W{1'b1}} : avg_w[DATA_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rad_q   <= radicand;
			guess_q <= radicand >> 1;
		end else if (cmd.update) begin
			guess_q <= new_guess;
		end
		if (cmd.sq_mul)
			prod_q <= PROD_W'(guess_q) * PROD_W'(guess_q);
		if (cmd.sq_err)
			err_q <= (sq_w > rad_w) ? (sq_w - rad_w) : (rad_w - sq_w);
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= DIV_W'(rad_q) << FRAC_BITS;
			// a zero guess divides as one LSB
			dvs_q <= (guess_q == '0) ? DATA_W'(1) : guess_q;
		end else if (cmd.div_step) begin
			if (!trial[DATA_W+1]) begin
				rem_q <= trial[DATA_W:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load)
				step_q <= '0;
			else if (cmd.update)
				step_q <= step_q + STEP_W'(1);
			if (cmd.div_start)
				dcnt_q <= DCNT_W'(DIV_W);
			else if (cmd.div_step)
				dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	assign sts.err_gt    = err_q > PROD_W'(tol_q);
	assign sts.steps_cap = step_q == STEP_W'(MAX_ITERS);
	assign sts.div_last  = dcnt_q == DCNT_W'(1);
	assign sts.out_busy  = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.emit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_root     <= guess_q;
			out_steps    <= (step_q > STEP_W'(STEPS_SAT)) ? STEPS_W'(STEPS_SAT)
			                                               : step_q[STEPS_W-1:0];
			out_not_conv <= sts.err_gt;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/newton_square_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// newton_square_root
// Square root of an unsigned Q16.16 value by Heron/Newton iteration.
// ----------------------------------------------------------------------------
// each step runs the radix-2 divider, one quotient bit per cycle
// one request in flight; a new request is taken while the last result waits
// reset clears control and sets tolerance to 66; no memory to clear
module newton_square_root #(
	parameter int MAX_ITERS = nsr_pkg::MAX_ITERS_DEF,
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // [31:0] radicand
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] root, [37:32] steps_taken, zero pad
	output logic        m_axis_tuser,  // [0] not_converged
	input  wire         cfg_we,
	input  wire  [15:0] cfg_wdata      // tolerance
);
	import nsr_pkg::*;

	localparam int CAP = (MAX_ITERS > STEPS_SAT) ? STEPS_SAT : MAX_ITERS;

	nsr_cmd_t            cmd;
	nsr_sts_t            sts;
	logic [DATA_W-1:0]   root;
	logic [STEPS_W-1:0]  steps_taken;
	logic                not_converged;

	nsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nsr_dp #(
		.MAX_ITERS (MAX_ITERS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.radicand     (s_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_root     (root),
		.out_steps    (steps_taken),
		.out_not_conv (not_converged)
	);

	assign m_axis_tdata = {2'b00, steps_taken, root};
	assign m_axis_tuser = not_converged;

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while another is in progress");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[37:32] <= STEPS_W'(CAP)))
		else $error("step count above cap");

	a_nc_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[37:32] == STEPS_W'(CAP)))
		else $error("not converged flagged before step cap");

	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("result overwrote an unclaimed result");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for newton_square_root. A directed table covers the
// radicand extremes, exact squares, the zero guess, the step cap and the
// tolerance extremes. A long random run then sweeps several tolerance
// settings under three flow-control mixes. Every result is checked field by
// field against a hand-typed result or a bit-accurate Heron iteration kept in the bench.
// ----------------------------------------------------------------------------
module tb;
	import nsr_pkg::*;

	localparam int DIR_ROWS    = 23;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 246;
	localparam int DRAIN_WAIT  = 8;
	localparam int TAIL_WAIT   = 64;
	localparam int SHOW_ERRORS = 10;

	typedef struct packed {
		logic [DATA_W-1:0]  root;
		logic [STEPS_W-1:0] steps;
		logic               not_conv;
	} root_result_t;

	typedef struct packed {
		logic [TOL_W-1:0]  tol;
		logic [DATA_W-1:0] radicand;
		logic              typed;
		root_result_t      want;
	} table_row_t;

	typedef struct {
		logic [DATA_W-1:0] radicand;
		bit                typed;
		root_result_t      want;
	} sqrt_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;   // [31:0] root, [37:32] steps_taken, zero pad
	logic        m_axis_tuser;   // [0] not_converged
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// bench copy of the tolerance register
	logic [TOL_W-1:0] tol_model = TOL_RESET;

	sqrt_request_t on_the_wire[$];  // driven, not yet taken by the block
	sqrt_request_t awaited[$];      // taken, result still to come

	int send_idle = 0;
	int recv_idle = 0;
	int sent_count = 0;
	int typed_count = 0;
	int results_seen = 0;
	int mismatches = 0;
	int tol_writes = 0;

	table_row_t dir_rows [0:DIR_ROWS-1];

	newton_square_root u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] square_error(input logic [DATA_W-1:0] g,
			input logic [DATA_W-1:0] r);
		logic [63:0] sq;
		sq = ({32'd0, g} * {32'd0, g}) >> FRAC_BITS_DEF;
		return (sq > {32'd0, r}) ? sq - {32'd0, r} : {32'd0, r} - sq;
	endfunction

	// heron iteration from half the radicand, truncating fixed point
	function automatic root_result_t heron_root(input logic [DATA_W-1:0] r,
			input logic [TOL_W-1:0] tol);
		logic [DATA_W-1:0] g;
		logic [63:0]       err;
		logic [63:0]       div;
		logic [63:0]       quo;
		logic [63:0]       nxt;
		int unsigned       n;
		root_result_t      res;
		g = r >> 1;
		err = square_error(g, r);
		n = 0;
		while (err > {48'd0, tol} && n < MAX_ITERS_DEF) begin
			div = (g == '0) ? 64'd1 : {32'd0, g};
			quo = ({32'd0, r} << FRAC_BITS_DEF) / div;
			nxt = (div + quo) >> 1;
			g = (nxt > 64'hFFFF_FFFF) ? '1 : nxt[DATA_W-1:0];
			err = square_error(g, r);
			n++;
		end
		res.root = g;
		res.steps = (n > STEPS_SAT) ? STEPS_W'(STEPS_SAT) : STEPS_W'(n);
		res.not_conv = (err > {48'd0, tol});
		return res;
	endfunction

	function automatic table_row_t dir_row(input logic [TOL_W-1:0] tol,
			input logic [DATA_W-1:0] rad, input logic typed, input logic [DATA_W-1:0] root,
			input logic [STEPS_W-1:0] steps, input logic nc);
		table_row_t t;
		t.tol = tol;
		t.radicand = rad;
		t.typed = typed;
		t.want.root = root;
		t.want.steps = steps;
		t.want.not_conv = nc;
		return t;
	endfunction

	function automatic logic [DATA_W-1:0] pick_radicand();
		logic [31:0] s;
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5: return $urandom >> $urandom_range(31);
			6, 7: begin
				// close to an exact square
				s = $urandom >> $urandom_range(8, 31);
				return 32'(({32'd0, s} * {32'd0, s}) >> FRAC_BITS_DEF) + $urandom_range(2);
			end
			8: return $urandom_range(15);
			default: return 32'hFFFF_FFFF - $urandom_range(255);
		endcase
	endfunction

	function automatic void flag_error(input string msg);
		mismatches++;
		if (mismatches <= SHOW_ERRORS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic void check_field(input string field, input logic [31:0] rad,
			input logic [31:0] want, input logic [31:0] got);
		if (got !== want)
			flag_error($sformatf("radicand %h: %s expected %h got %h", rad, field, want, got));
	endfunction

	task automatic send_radicand(input logic [DATA_W-1:0] rad, input bit typed,
			input root_result_t want);
		sqrt_request_t req;
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		req.radicand = rad;
		req.typed = typed;
		req.want = want;
		on_the_wire.push_back(req);
		sent_count++;
		if (typed)
			typed_count++;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rad;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// the register is only written with the block drained and idle
	task automatic set_tolerance(input logic [TOL_W-1:0] tol);
		s_axis_tvalid <= 1'b0;
		while (awaited.size() != 0 || on_the_wire.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= tol;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_model = tol;
		tol_writes++;
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin : watch
		root_result_t  got;
		sqrt_request_t exp_req;
		sqrt_request_t req;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.root = m_axis_tdata[31:0];
				got.steps = m_axis_tdata[32 +: STEPS_W];
				got.not_conv = m_axis_tuser;
				results_seen++;
				if (awaited.size() == 0) begin
					flag_error($sformatf("result with no request awaiting: root %h steps %0d nc %0b",
						got.root, got.steps, got.not_conv));
				end else begin
					exp_req = awaited.pop_front();
					check_field("root", exp_req.radicand, exp_req.want.root, got.root);
					check_field("steps_taken", exp_req.radicand, 32'(exp_req.want.steps),
						32'(got.steps));
					check_field("not_converged", exp_req.radicand, 32'(exp_req.want.not_conv),
						32'(got.not_conv));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req = on_the_wire.pop_front();
				req.radicand = s_axis_tdata;
				if (!req.typed)
					req.want = heron_root(s_axis_tdata, tol_model);
				awaited.push_back(req);
			end
		end
	end

	initial begin : stimulus
		int phase;
		logic [TOL_W-1:0] tol;
		dir_rows = '{
			dir_row(TOL_RESET, 32'h0000_0000, 1'b1, 32'h0000_0000, 6'd0, 1'b0),
			dir_row(TOL_RESET, 32'h0000_0001, 1'b1, 32'h0000_0000, 6'd0, 1'b0),
			// error exactly at the tolerance counts as converged
			dir_row(TOL_RESET, 32'h0000_0042, 1'b1, 32'h0000_0021, 6'd0, 1'b0),
			dir_row(TOL_RESET, 32'h0000_0043, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'h0004_0000, 1'b1, 32'h0002_0000, 6'd0, 1'b0),
			dir_row(TOL_RESET, 32'h0001_0000, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'h0002_0000, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'h0009_0000, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'h0100_0000, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'h0000_FFFF, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'h8000_0000, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'hAAAA_AAAA, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'h5555_5555, 1'b0, '0, '0, 1'b0),
			dir_row(TOL_RESET, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0),
			dir_row(16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 6'd0, 1'b0),
			// zero first guess, must be bumped to one lsb
			dir_row(16'h0000, 32'h0000_0001, 1'b0, '0, '0, 1'b0),
			dir_row(16'h0000, 32'h0000_0002, 1'b0, '0, '0, 1'b0),
			dir_row(16'h0000, 32'h0004_0000, 1'b1, 32'h0002_0000, 6'd0, 1'b0),
			// irrational root at zero tolerance runs into the step cap
			dir_row(16'h0000, 32'h0002_0000, 1'b0, '0, '0, 1'b0),
			dir_row(16'h0000, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0),
			dir_row(16'hFFFF, 32'h0001_0000, 1'b1, 32'h0000_8000, 6'd0, 1'b0),
			dir_row(16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0)
		};
		send_idle = 26;
		recv_idle = 67;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].tol != tol_model)
				set_tolerance(dir_rows[i].tol);
			send_radicand(dir_rows[i].radicand, dir_rows[i].typed, dir_rows[i].want);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			send_idle = (phase < 2) ? 26 : (phase < 4) ? 67 : 0;
			recv_idle = (phase < 2) ? 67 : (phase < 4) ? 26 : 0;
			case (phase)
				0: tol = 16'hFFFF;
				1: tol = 16'h0000;
				2: tol = TOL_W'($urandom_range(255));
				3: tol = TOL_W'($urandom);
				4: tol = TOL_RESET;
				default: tol = TOL_W'($urandom_range(16));
			endcase
			set_tolerance(tol);
			repeat (PHASE_ITEMS) send_radicand(pick_radicand(), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (awaited.size() != 0 || on_the_wire.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("%0d radicands sent (%0d with hand-typed results), %0d results checked, %0d mismatches",
			sent_count, typed_count, results_seen, mismatches);
		$display("%0d tolerance writes incl. 0 and 65535, three flow-control mixes",
			tol_writes);
		if (mismatches == 0)
			$display("PASS newton_square_root");
		else
			$display("FAIL newton_square_root");
		$finish;
	end

	initial begin : watchdog
		#200_000_000;
		$display("timeout: %0d results still awaited", awaited.size() + on_the_wire.size());
		$display("FAIL newton_square_root");
		$finish;
	end

endmodule
